// ===== rtl/core/ted_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_pkg
// Shared types and codes for the text encoding detector.
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 3;

  localparam logic [CodeW-1:0] CODE_NONE  = 3'd0;
  localparam logic [CodeW-1:0] CODE_ASCII = 3'd1;
  localparam logic [CodeW-1:0] CODE_UTF8  = 3'd2;
  localparam logic [CodeW-1:0] CODE_GBK   = 3'd3;
  localparam logic [CodeW-1:0] CODE_BIG5  = 3'd4;

  localparam logic [ByteW-1:0] DBCS_LEAD_LO  = 8'h81;
  localparam logic [ByteW-1:0] DBCS_HI       = 8'hFE;
  localparam logic [ByteW-1:0] DBCS_TRAIL_LO = 8'h40;
  localparam logic [ByteW-1:0] DBCS_DEL      = 8'h7F;

  // Per-message scan state.
  typedef struct packed {
    logic       any_byte_seen;
    logic       non_ascii_seen;
    logic [1:0] utf8_cont_due;
    logic       utf8_failed;
    logic       gbk_trail_due;
    logic       gbk_failed;
    logic       big5_trail_due;
    logic       big5_failed;
  } scan_state_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             fallback;
  } verdict_t;

endpackage

// ===== rtl/core/ted_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_scan
// Running UTF-8 / GBK / Big5 structure checks, one byte per word.
// ----------------------------------------------------------------------------
module ted_scan import ted_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [ByteW-1:0] byte_value,
  input  logic             has_byte,
  input  logic             is_last,
  output scan_state_t      st_nxt
);

  scan_state_t st_r;

  // Double-byte check; allow_del lets 0x7F through as a trail byte.
  function automatic logic [1:0] dbcs_step(input logic due, input logic failed,
                                           input logic [ByteW-1:0] b,
                                           input logic allow_del);
    logic ok;
    logic due_n;
    logic fail_n;
    begin
      ok     = 1'b0;
      due_n  = due;
      fail_n = failed;
      if (due) begin
        ok = (b >= DBCS_TRAIL_LO) && (b <= DBCS_HI) && (allow_del || b != DBCS_DEL);
        if (!ok) fail_n = 1'b1;
        due_n = 1'b0;
      end else if (b[7]) begin
        if (b >= DBCS_LEAD_LO && b <= DBCS_HI) due_n = 1'b1;
        else fail_n = 1'b1;
      end
      dbcs_step = {due_n, fail_n};
    end
  endfunction

  always_comb begin
    st_nxt = st_r;
    if (has_byte) begin
      st_nxt.any_byte_seen = 1'b1;
      if (byte_value[7]) st_nxt.non_ascii_seen = 1'b1;

      if (st_r.utf8_cont_due != 2'd0) begin
        if (byte_value[7:6] != 2'b10) st_nxt.utf8_failed = 1'b1;
        st_nxt.utf8_cont_due = st_r.utf8_cont_due - 2'd1;
      end else if (!byte_value[7]) begin
        st_nxt.utf8_cont_due = 2'd0;
      end else if (byte_value[7:5] == 3'b110) begin
        st_nxt.utf8_cont_due = 2'd1;
      end else if (byte_value[7:4] == 4'b1110) begin
        st_nxt.utf8_cont_due = 2'd2;
      end else if (byte_value[7:3] == 5'b11110) begin
        st_nxt.utf8_cont_due = 2'd3;
      end else begin
        st_nxt.utf8_failed = 1'b1;
      end

      {st_nxt.gbk_trail_due, st_nxt.gbk_failed} =
        dbcs_step(st_r.gbk_trail_due, st_r.gbk_failed, byte_value, 1'b0);
      {st_nxt.big5_trail_due, st_nxt.big5_failed} =
        dbcs_step(st_r.big5_trail_due, st_r.big5_failed, byte_value, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      // last word closes the message: start clean for the next one
      st_r <= is_last ? scan_state_t'('0) : st_nxt;
    end
  end

endmodule

// ===== rtl/core/ted_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_decide
// Priority decision from the scan state at message end.
// ----------------------------------------------------------------------------
module ted_decide import ted_pkg::*; (
  input  scan_state_t st,
  output verdict_t    verdict
);

  always_comb begin
    verdict.fallback = 1'b0;
    priority if (!st.any_byte_seen) begin
      verdict.code = CODE_NONE;
    end else if (!st.non_ascii_seen) begin
      verdict.code = CODE_ASCII;
    end else if (!st.utf8_failed && st.utf8_cont_due == 2'd0) begin
      verdict.code = CODE_UTF8;
    end else if (!st.gbk_failed && !st.gbk_trail_due) begin
      verdict.code = CODE_GBK;
    end else if (!st.big5_failed && !st.big5_trail_due) begin
      verdict.code = CODE_BIG5;
    end else begin
      // nothing validated: guess UTF-8
      verdict.code     = CODE_UTF8;
      verdict.fallback = 1'b1;
    end
  end

endmodule

// ===== rtl/core/text_encoding_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_detector_unit
// Takes a message one byte per word and, on its last word, returns one
// encoding code (none, US-ASCII, UTF-8, GBK, Big5) with a fallback flag. A
// word is taken every cycle while input is not held off; the result for a last
// word appears in the output register in the cycle after acceptance, set by
// a single pass through the validator and priority logic. Words that are not
// last give no result. Input is held off only while a result waits in the
// output register and out_ready is low.
// ----------------------------------------------------------------------------
module text_encoding_detector_unit import ted_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte_value,
  input  logic             in_has_byte,
  input  logic             in_is_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CodeW-1:0] out_encoding_code,
  output logic             out_fallback_guess
);

  scan_state_t st_nxt;
  verdict_t    verdict;
  logic        in_acc;

  logic             out_valid_r,   out_valid_nxt;
  logic [CodeW-1:0] out_code_r;
  logic             out_fallback_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  ted_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .byte_value (in_byte_value),
    .has_byte   (in_has_byte),
    .is_last    (in_is_last),
    .st_nxt     (st_nxt)
  );

  ted_decide u_decide (
    .st      (st_nxt),
    .verdict (verdict)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && in_is_last) out_valid_nxt = 1'b1;
    else if (out_ready)       out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_is_last) begin
      out_code_r     <= verdict.code;
      out_fallback_r <= verdict.fallback;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_encoding_code  = out_code_r;
  assign out_fallback_guess = out_fallback_r;

endmodule

// ===== rtl/core/ted_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_checker
// Port-level checks for text_encoding_detector_unit.
// ----------------------------------------------------------------------------
module ted_checker import ted_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_is_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CodeW-1:0] out_encoding_code,
  input logic             out_fallback_guess
);

  // A last word always lands a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> out_valid)
    else $error("last word produced no result");

  // Input is never held off while the output slot is free or draining.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output slot");

  // Fallback only comes with the UTF-8 guess.
  a_fallback_utf8: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fallback_guess |-> out_encoding_code == CODE_UTF8)
    else $error("fallback flag with non-UTF-8 code");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_encoding_code <= CODE_BIG5)
    else $error("encoding code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_encoding_code)
      && $stable(out_fallback_guess))
    else $error("stalled result changed");

endmodule

bind text_encoding_detector_unit ted_checker u_ted_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_is_last         (in_is_last),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_encoding_code  (out_encoding_code),
  .out_fallback_guess (out_fallback_guess)
);
